// ----- hdl/lr_pkg.sv -----
// lr_pkg: shared types for the line rasterizer core.
// Holds the per-line direction flags and the walker state encoding.
// No dependencies.
`default_nettype none

package lr_pkg;

    // Direction and axis flags of one line, set by the front end.
    typedef struct packed {
        logic x_major;  // x is the major axis
        logic y_down;   // y steps toward lower values
        logic x_down;   // x steps toward lower values
    } t_line_ctrl;

    localparam int unsigned LineCtrlBits = $bits(t_line_ctrl);

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } t_walk_state;

endpackage

`default_nettype wire

// ----- hdl/line_rasterizer_core.sv -----
// line_rasterizer_core: Bresenham line rasterizer, front end + queue + walker.
// Depends on lr_pkg, lr_front, lr_queue, lr_walker.
// Path: request, front-end register, queue, walker setup load, output register.
// Throughput: one point a cycle when the output is not stalled; a line of major
// delta D gives D + 1 points and holds the walker for one setup load besides.
// Reset: synchronous, active low; clears valids, queue and walker state.
`default_nettype none

module line_rasterizer_core
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 6
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Line requests.
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata, low to high: start_x, start_y, end_x, end_y, zero pad.
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // Emitted points.
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata, low to high: point_x, point_y, zero pad.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
    // tlast: last point of the line.
    output logic                                        m_axis_tlast
);

    localparam int unsigned OutBits    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned SetupBits  = 5 * COORD_BITS + 3 + LineCtrlBits;
    localparam int unsigned QueueDepth = 2;

    // Front end to queue.
    logic                  fe_valid;
    logic [SetupBits-1:0]  fe_setup;
    logic                  q_not_full;
    // Queue to walker.
    logic                  q_not_empty;
    logic                  q_pop;
    logic [SetupBits-1:0]  q_setup;
    // Walker point.
    logic [COORD_BITS-1:0] pt_x;
    logic [COORD_BITS-1:0] pt_y;

    // Front end: classifies a request (axis, directions, deltas, error seed).
    lr_front #(
        .COORD_BITS (COORD_BITS),
        .SETUP_BITS (SetupBits)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_start_x (s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_end_x   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_end_y   (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_valid   (fe_valid),
        .i_ready   (q_not_full),
        .o_setup   (fe_setup)
    );

    // Short queue so the front end keeps taking requests during a walk.
    lr_queue #(
        .WIDTH (SetupBits),
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fe_valid),
        .o_not_full  (q_not_full),
        .i_data      (fe_setup),
        .o_not_empty (q_not_empty),
        .i_pop       (q_pop),
        .o_data      (q_setup)
    );

    // Back end: walks the line one point per cycle while the output is not stalled.
    lr_walker #(
        .COORD_BITS (COORD_BITS),
        .SETUP_BITS (SetupBits)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .o_q_pop   (q_pop),
        .i_q_setup (q_setup),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_point_x (pt_x),
        .o_point_y (pt_y),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OutBits'({pt_y, pt_x});

endmodule

`default_nettype wire

// ----- hdl/lr_front.sv -----
// lr_front: accepts a line request, works out deltas, axis, directions
// and the initial error term, and holds the setup for the queue.
// Depends on lr_pkg.
`default_nettype none

module lr_front
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 6,
    parameter int unsigned SETUP_BITS = 5 * COORD_BITS + 3 + LineCtrlBits
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [SETUP_BITS-1:0]      o_setup
);

    localparam int unsigned ErrBits = COORD_BITS + 3;

    logic                  r_valid;
    logic                  n_valid;
    logic [SETUP_BITS-1:0] r_setup;
    logic [SETUP_BITS-1:0] n_setup;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] d_major;
    logic [COORD_BITS-1:0] d_minor;
    logic [ErrBits-1:0]    err_init;
    t_line_ctrl            ctrl;
    logic                  take;

    // Ties go to y: x is major only when strictly longer.
    always_comb begin
        ctrl.x_down  = !(i_end_x > i_start_x);
        ctrl.y_down  = !(i_end_y > i_start_y);
        dx           = ctrl.x_down ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        dy           = ctrl.y_down ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        ctrl.x_major = (dx > dy);
        d_major      = ctrl.x_major ? dx : dy;
        d_minor      = ctrl.x_major ? dy : dx;
        err_init     = {2'b00, d_minor, 1'b0} - {3'b000, d_major};
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        n_setup = r_setup;
        if (take) begin
            n_valid = 1'b1;
            n_setup = {ctrl, err_init, d_minor, d_major, i_start_y, i_start_x};
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_setup <= n_setup;
    end

    assign o_valid = r_valid;
    assign o_setup = r_setup;

endmodule

`default_nettype wire

// ----- hdl/lr_queue.sv -----
// lr_queue: small FIFO of line setups between front end and walker.
// Register file with combinational read head; depth a power of two.
// Depends on lr_pkg only by convention of the project.
`default_nettype none

module lr_queue
    import lr_pkg::*;
#(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_not_full,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_not_empty,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int unsigned AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CountBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]     r_mem [DEPTH];
    logic [AddrBits-1:0]  r_wr_ptr;
    logic [AddrBits-1:0]  r_rd_ptr;
    logic [CountBits-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_not_full  = (r_count != CountBits'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AddrBits'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AddrBits'(1);
            end
            priority if (do_push && !do_pop) begin
                r_count <= r_count + CountBits'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CountBits'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(DEPTH))
        else $error("queue count above depth");

    a_empty_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |=> (r_count <= CountBits'(1)))
        else $error("queue count moved wrongly from empty");

endmodule

`default_nettype wire

// ----- hdl/lr_walker.sv -----
// lr_walker: takes one line setup from the queue and walks its points,
// one per cycle when not stalled, into an output register that holds a point under stall.
// Depends on lr_pkg.
`default_nettype none

module lr_walker
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 6,
    parameter int unsigned SETUP_BITS = 5 * COORD_BITS + 3 + LineCtrlBits
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_pop,
    input  wire logic [SETUP_BITS-1:0] i_q_setup,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COORD_BITS-1:0]      o_point_x,
    output logic [COORD_BITS-1:0]      o_point_y,
    output logic                       o_last
);

    localparam int unsigned ErrBits  = COORD_BITS + 3;
    localparam int unsigned LeftBits = COORD_BITS + 1;

    t_walk_state           r_state;
    t_walk_state           n_state;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] n_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COORD_BITS-1:0] n_y;
    logic [ErrBits-1:0]    r_err;
    logic [ErrBits-1:0]    n_err;
    logic [LeftBits-1:0]   r_left;
    logic [LeftBits-1:0]   n_left;
    logic [COORD_BITS-1:0] r_dmaj;
    logic [COORD_BITS-1:0] n_dmaj;
    logic [COORD_BITS-1:0] r_dmin;
    logic [COORD_BITS-1:0] n_dmin;
    t_line_ctrl            r_ctrl;
    t_line_ctrl            n_ctrl;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] n_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COORD_BITS-1:0] n_out_y;
    logic                  r_out_last;
    logic                  n_out_last;

    logic                  adv;
    logic                  minor_step;
    logic                  step_x;
    logic                  step_y;
    logic                  is_last;

    // Setup fields, lowest first: start x, start y, major, minor, error, flags.
    logic [COORD_BITS-1:0] q_sx;
    logic [COORD_BITS-1:0] q_sy;
    logic [COORD_BITS-1:0] q_dmaj;
    logic [COORD_BITS-1:0] q_dmin;
    logic [ErrBits-1:0]    q_err;
    t_line_ctrl            q_ctrl;

    assign q_sx   = i_q_setup[COORD_BITS-1:0];
    assign q_sy   = i_q_setup[2*COORD_BITS-1:COORD_BITS];
    assign q_dmaj = i_q_setup[3*COORD_BITS-1:2*COORD_BITS];
    assign q_dmin = i_q_setup[4*COORD_BITS-1:3*COORD_BITS];
    assign q_err  = i_q_setup[4*COORD_BITS+ErrBits-1:4*COORD_BITS];
    assign q_ctrl = t_line_ctrl'(i_q_setup[SETUP_BITS-1:4*COORD_BITS+ErrBits]);

    // A point moves out when the output register is empty or being drained.
    assign adv        = (r_state == WALK_RUN) && (!r_out_valid || i_ready);
    assign minor_step = !r_err[ErrBits-1];
    assign step_x     = r_ctrl.x_major || minor_step;
    assign step_y     = !r_ctrl.x_major || minor_step;
    assign is_last    = (r_left == LeftBits'(1));

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_err       = r_err;
        n_left      = r_left;
        n_dmaj      = r_dmaj;
        n_dmin      = r_dmin;
        n_ctrl      = r_ctrl;
        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        unique case (r_state)
            WALK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_x     = q_sx;
                    n_y     = q_sy;
                    n_err   = q_err;
                    n_dmaj  = q_dmaj;
                    n_dmin  = q_dmin;
                    n_ctrl  = q_ctrl;
                    n_left  = {1'b0, q_dmaj} + LeftBits'(1);
                    n_state = WALK_RUN;
                end
            end
            WALK_RUN: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_x;
                    n_out_y     = r_y;
                    n_out_last  = is_last;
                    n_left      = r_left - LeftBits'(1);
                    n_err       = minor_step
                                ? r_err + {2'b00, r_dmin, 1'b0} - {2'b00, r_dmaj, 1'b0}
                                : r_err + {2'b00, r_dmin, 1'b0};
                    if (step_x) begin
                        n_x = r_ctrl.x_down ? r_x - COORD_BITS'(1) : r_x + COORD_BITS'(1);
                    end
                    if (step_y) begin
                        n_y = r_ctrl.y_down ? r_y - COORD_BITS'(1) : r_y + COORD_BITS'(1);
                    end
                    if (is_last) begin
                        n_state = WALK_IDLE;
                    end
                end
            end
            default: begin
                n_state = WALK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WALK_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_err      <= n_err;
        r_dmaj     <= n_dmaj;
        r_dmin     <= n_dmin;
        r_ctrl     <= n_ctrl;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_valid   = r_out_valid;
    assign o_point_x = r_out_x;
    assign o_point_y = r_out_y;
    assign o_last    = r_out_last;

    a_run_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == WALK_RUN) |-> (r_left != '0))
        else $error("walking with no points left");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_last) |=> (r_state == WALK_IDLE) && r_out_valid && r_out_last)
        else $error("last point did not end the walk");

    a_mid_keeps_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_last) |=> (r_state == WALK_RUN) && !r_out_last)
        else $error("walk ended before the last point");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == WALK_IDLE) && i_q_valid)
        else $error("setup popped while walking");

endmodule

`default_nettype wire

// ----- verif/tb_line_rasterizer_core.sv -----
// tb_line_rasterizer_core: self-checking bench for the Bresenham line core.
// Predicts each line's points in-bench and checks the point stream in order.
// Depends on lr_pkg and line_rasterizer_core.
`timescale 1ns / 100ps

module tb_line_rasterizer_core;
    import lr_pkg::*;

    localparam int unsigned CoordBits   = 6;
    localparam int          CoordMax    = (1 << CoordBits) - 1;
    localparam int          RandomLines = 250;
    localparam int          StallLimit  = 2000;  // idle cycles with no item moving
    localparam int          DrainCycles = 20;

    typedef logic [CoordBits-1:0] t_coord;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    // start_x, start_y, end_x, end_y from bit 0 up
    logic [23:0] s_axis_tdata  = '0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // point_x, point_y, zero pad from bit 0 up
    wire logic [15:0] m_axis_tdata;
    wire logic   m_axis_tlast;

    t_point pending_points[$];
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    bit     send_gaps_on   = 1'b0;
    bit     recv_stalls_on = 1'b0;
    int     stall_left     = 0;

    line_rasterizer_core #(.COORD_BITS(CoordBits)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Walk one line the Bresenham way and queue its points.
    function automatic void predict_line(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        t_line_ctrl dirs;
        int         dx;
        int         dy;
        int         d_major;
        int         d_minor;
        int         err;
        bit         minor_step;
        t_coord     cx;
        t_coord     cy;
        t_point     pt;
        dx           = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        dy           = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        dirs.x_down  = !(ex > sx);
        dirs.y_down  = !(ey > sy);
        dirs.x_major = dx > dy;  // a tie makes y the major axis
        d_major      = dirs.x_major ? dx : dy;
        d_minor      = dirs.x_major ? dy : dx;
        err          = 2 * d_minor - d_major;
        cx           = sx;
        cy           = sy;
        for (int left = d_major; left >= 0; left--) begin
            pt.x    = cx;
            pt.y    = cy;
            pt.last = (left == 0);
            pending_points.push_back(pt);
            minor_step = (err >= 0);
            err += minor_step ? 2 * d_minor - 2 * d_major : 2 * d_minor;
            if (dirs.x_major) begin
                if (minor_step)
                    cy = dirs.y_down ? cy - t_coord'(1) : cy + t_coord'(1);
                cx = dirs.x_down ? cx - t_coord'(1) : cx + t_coord'(1);
            end else begin
                if (minor_step)
                    cx = dirs.x_down ? cx - t_coord'(1) : cx + t_coord'(1);
                cy = dirs.y_down ? cy - t_coord'(1) : cy + t_coord'(1);
            end
        end
    endfunction

    // Offer one line request and hold it until the core takes it.
    // tvalid is left high so back-to-back requests stream without a bubble.
    task automatic send_line(input int sx, input int sy,
                             input int ex, input int ey);
        int     gap;
        t_coord sx_c;
        t_coord sy_c;
        t_coord ex_c;
        t_coord ey_c;
        sx_c = t_coord'(sx);
        sy_c = t_coord'(sy);
        ex_c = t_coord'(ex);
        ey_c = t_coord'(ey);
        gap  = send_gaps_on ? pick_gap() : 0;
        if (gap != 0 && $urandom_range(0, 2) != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ey_c, ex_c, sy_c, sx_c};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_line(sx_c, sy_c, ex_c, ey_c);
    endtask

    // Point sink: check each taken point, then pick the next ready value.
    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d last=%0b",
                       m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_axis_tdata[5:0] !== exp_pt.x) begin
                    $error("point_x: expected %0d, got %0d", exp_pt.x, m_axis_tdata[5:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[11:6] !== exp_pt.y) begin
                    $error("point_y: expected %0d, got %0d", exp_pt.y, m_axis_tdata[11:6]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_pt.last) begin
                    $error("last: expected %0b, got %0b", exp_pt.last, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:12] !== 4'h0) begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[15:12]);
                    mismatch_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // Start equals end: a single point flagged last.
    task automatic test_degenerate();
        send_line(0, 0, 0, 0);
        send_line(CoordMax, CoordMax, CoordMax, CoordMax);
        send_line(17, 42, 17, 42);
    endtask

    // Pure horizontal and vertical lines, both directions, full span included.
    task automatic test_axis_lines();
        send_line(0, 5, CoordMax, 5);
        send_line(CoordMax, 60, 0, 60);
        send_line(9, 0, 9, CoordMax);
        send_line(50, CoordMax, 50, 0);
        send_line(30, 30, 34, 30);
        send_line(30, 30, 30, 26);
    endtask

    // Shallow and steep lines in every octant, plus diagonals where y wins the tie.
    task automatic test_octants();
        send_line(10, 10, 25, 14);
        send_line(25, 14, 10, 10);
        send_line(10, 20, 25, 16);
        send_line(25, 16, 10, 20);
        send_line(10, 10, 14, 25);
        send_line(14, 25, 10, 10);
        send_line(40, 10, 36, 25);
        send_line(36, 25, 40, 10);
        send_line(0, 0, CoordMax, CoordMax);
        send_line(CoordMax, 0, 0, CoordMax);
        send_line(CoordMax, CoordMax, 0, 0);
        send_line(0, CoordMax, 5, CoordMax - 5);
        send_line(0, 1, CoordMax, 0);
    endtask

    // Mostly short lines anywhere on the grid, some long ones and some full spans.
    task automatic test_random_lines();
        int sel;
        int ex;
        int ey;
        int sx;
        int sy;
        for (int n = 0; n < RandomLines; n++) begin
            if (n % 50 == 0) begin
                send_gaps_on   = ($urandom_range(0, 3) != 0);
                recv_stalls_on = ($urandom_range(0, 3) != 0);
            end
            sel = $urandom_range(0, 9);
            sx  = $urandom_range(0, CoordMax);
            sy  = $urandom_range(0, CoordMax);
            if (sel < 7) begin
                ex = sx + int'($urandom_range(0, 14)) - 7;
                ey = sy + int'($urandom_range(0, 14)) - 7;
                ex = (ex < 0) ? 0 : (ex > CoordMax) ? CoordMax : ex;
                ey = (ey < 0) ? 0 : (ey > CoordMax) ? CoordMax : ey;
            end else if (sel < 9) begin
                ex = $urandom_range(0, CoordMax);
                ey = $urandom_range(0, CoordMax);
            end else begin
                sx = $urandom_range(0, 1) ? CoordMax : 0;
                ex = CoordMax - sx;
                ey = $urandom_range(0, CoordMax);
            end
            send_line(sx, sy, ex, ey);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines first back to back, then with idling on both sides.
        test_degenerate();
        test_axis_lines();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        test_octants();
        test_random_lines();

        // Drop the request right at the edge that took the last line.
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
